// ----- sv/rft_pkg.sv -----
// Shared constants and types for the rise/fall to tilt converter.
`default_nettype none

package rft_pkg;

  // Default field widths.
  localparam int unsigned AMP_BITS_DEF  = 16;
  localparam int unsigned DUR_BITS_DEF  = 16;
  localparam int unsigned FRAC_BITS_DEF = 14;

  // Entries in the queue between the front and back parts (a power of two).
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classification flags that travel with each event.
  typedef struct packed {
    logic degen;    // a denominator is zero
    logic amp_neg;  // |rise| < |fall|
    logic dur_neg;  // rise duration < fall duration
  } rft_flags_t;

  localparam int unsigned FLAGS_BITS = $bits(rft_flags_t);

endpackage : rft_pkg

`default_nettype wire

// ----- sv/rft_front.sv -----
// Front part: accepts events, forms sums, difference magnitudes and flags.
`default_nettype none

module rft_front #(
  parameter int unsigned AMP_BITS = rft_pkg::AMP_BITS_DEF,
  parameter int unsigned DUR_BITS = rft_pkg::DUR_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [AMP_BITS-1:0] in_rise_amp,
  input  wire logic signed [AMP_BITS-1:0] in_fall_amp,
  input  wire logic        [DUR_BITS-1:0] in_rise_dur,
  input  wire logic        [DUR_BITS-1:0] in_fall_dur,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output rft_pkg::rft_flags_t             out_flags,
  output logic             [AMP_BITS:0]   out_amp_sum,
  output logic             [AMP_BITS-1:0] out_amp_num,
  output logic             [DUR_BITS:0]   out_dur_sum,
  output logic             [DUR_BITS-1:0] out_dur_num
);

  logic                valid_r, valid_nxt;
  rft_pkg::rft_flags_t flags_r, flags_nxt;
  logic [AMP_BITS:0]   amp_sum_r, amp_sum_nxt;
  logic [AMP_BITS-1:0] amp_num_r, amp_num_nxt;
  logic [DUR_BITS:0]   dur_sum_r, dur_sum_nxt;
  logic [DUR_BITS-1:0] dur_num_r, dur_num_nxt;

  logic [AMP_BITS-1:0] mag_rise, mag_fall;
  logic                accept;

  // The holding register takes a new beat whenever it is empty or draining.
  assign in_ready = !valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Classification: magnitudes, sums and signed differences as sign plus magnitude.
  always_comb begin
    mag_rise = in_rise_amp[AMP_BITS-1] ? (~in_rise_amp + 1'b1) : in_rise_amp;
    mag_fall = in_fall_amp[AMP_BITS-1] ? (~in_fall_amp + 1'b1) : in_fall_amp;

    amp_sum_nxt = {1'b0, mag_rise} + {1'b0, mag_fall};
    dur_sum_nxt = {1'b0, in_rise_dur} + {1'b0, in_fall_dur};

    flags_nxt.amp_neg = mag_rise < mag_fall;
    flags_nxt.dur_neg = in_rise_dur < in_fall_dur;
    flags_nxt.degen   = (amp_sum_nxt == '0) || (dur_sum_nxt == '0);

    amp_num_nxt = flags_nxt.amp_neg ? (mag_fall - mag_rise) : (mag_rise - mag_fall);
    dur_num_nxt = flags_nxt.dur_neg ? (in_fall_dur - in_rise_dur)
                                    : (in_rise_dur - in_fall_dur);

    valid_nxt = accept ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      flags_r   <= flags_nxt;
      amp_sum_r <= amp_sum_nxt;
      amp_num_r <= amp_num_nxt;
      dur_sum_r <= dur_sum_nxt;
      dur_num_r <= dur_num_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_flags   = flags_r;
  assign out_amp_sum = amp_sum_r;
  assign out_amp_num = amp_num_r;
  assign out_dur_sum = dur_sum_r;
  assign out_dur_num = dur_num_r;

endmodule : rft_front

`default_nettype wire

// ----- sv/rft_queue.sv -----
// Small first-in first-out queue between the front and back parts.
`default_nettype none

module rft_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = rft_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    entry_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                push, pop;

  assign push_ready = count_r != CNT_BITS'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : rft_queue

`default_nettype wire

// ----- sv/rft_div.sv -----
// Pipelined unsigned divider: (num * 2^(QB-1)) / den, one quotient bit per stage.
`default_nettype none

module rft_div #(
  parameter int unsigned W  = 17,
  parameter int unsigned QB = 15
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [W-1:0]  num,   // must not exceed den
  input  wire logic [W-1:0]  den,
  output logic      [QB-1:0] quo
);

  logic [W-1:0]  rem_r [QB];
  logic [W-1:0]  den_r [QB];
  logic [QB-1:0] quo_r [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic [W-1:0]  den_in;
    logic [QB-1:0] quo_in;
    logic          take;

    // The first stage sees the numerator itself; later ones the doubled remainder.
    if (i == 0) begin : g_first
      assign trial  = {1'b0, num};
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign trial  = {rem_r[i-1], 1'b0};
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    // Compare and subtract; the remainder stays below the divisor.
    assign diff = trial - {1'b0, den_in};
    assign take = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= take ? diff[W-1:0] : trial[W-1:0];
        den_r[i] <= den_in;
        quo_r[i] <= {quo_in[QB-2:0], take};
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule : rft_div

`default_nettype wire

// ----- sv/rft_back.sv -----
// Back part: two lockstep divider pipelines, sign restore, mean and result register.
`default_nettype none

module rft_back #(
  parameter int unsigned AMP_BITS  = rft_pkg::AMP_BITS_DEF,
  parameter int unsigned DUR_BITS  = rft_pkg::DUR_BITS_DEF,
  parameter int unsigned FRAC_BITS = rft_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire rft_pkg::rft_flags_t         in_flags,
  input  wire logic        [AMP_BITS:0]    in_amp_sum,
  input  wire logic        [AMP_BITS-1:0]  in_amp_num,
  input  wire logic        [DUR_BITS:0]    in_dur_sum,
  input  wire logic        [DUR_BITS-1:0]  in_dur_num,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic             [AMP_BITS:0]    out_tilt_amp,
  output logic             [DUR_BITS:0]    out_tilt_dur,
  output logic signed      [FRAC_BITS+1:0] out_tilt_value,
  output logic                             out_degenerate
);

  localparam int unsigned QB = FRAC_BITS + 1;  // quotient bits, up to 2^FRAC_BITS
  localparam int unsigned SB = FRAC_BITS + 3;  // width of the signed sum of ratios

  logic                advance;
  logic                stg_valid_r [QB];
  rft_pkg::rft_flags_t stg_flags_r [QB];
  logic [AMP_BITS:0]   stg_amp_r   [QB];
  logic [DUR_BITS:0]   stg_dur_r   [QB];

  logic [QB-1:0]       quo_amp, quo_dur;
  rft_pkg::rft_flags_t last_flags;
  logic signed [SB-1:0] ratio_amp, ratio_dur, ratio_sum, ratio_half;

  logic                     out_valid_r, out_valid_nxt;
  logic [AMP_BITS:0]        tilt_amp_r;
  logic [DUR_BITS:0]        tilt_dur_r;
  logic signed [FRAC_BITS+1:0] tilt_value_r, tilt_value_nxt;
  logic                     degen_r;

  // The whole pipeline moves together whenever the result register can take a beat.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  rft_div #(.W(AMP_BITS + 1), .QB(QB)) u_div_amp (
    .clk (clk),
    .en  (advance),
    .num ({1'b0, in_amp_num}),
    .den (in_amp_sum),
    .quo (quo_amp)
  );

  rft_div #(.W(DUR_BITS + 1), .QB(QB)) u_div_dur (
    .clk (clk),
    .en  (advance),
    .num ({1'b0, in_dur_num}),
    .den (in_dur_sum),
    .quo (quo_dur)
  );

  // Side band that travels alongside the divider stages.
  for (genvar i = 0; i < QB; i++) begin : g_side
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_valid_r[i] <= 1'b0;
        end else if (advance) begin
          stg_valid_r[i] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (advance) begin
          stg_flags_r[i] <= in_flags;
          stg_amp_r[i]   <= in_amp_sum;
          stg_dur_r[i]   <= in_dur_sum;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_valid_r[i] <= 1'b0;
        end else if (advance) begin
          stg_valid_r[i] <= stg_valid_r[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (advance) begin
          stg_flags_r[i] <= stg_flags_r[i-1];
          stg_amp_r[i]   <= stg_amp_r[i-1];
          stg_dur_r[i]   <= stg_dur_r[i-1];
        end
      end
    end
  end

  assign last_flags = stg_flags_r[QB-1];

  // Restore signs, add the two ratios and halve toward zero.
  always_comb begin
    ratio_amp  = last_flags.amp_neg ? -$signed({2'b00, quo_amp}) : $signed({2'b00, quo_amp});
    ratio_dur  = last_flags.dur_neg ? -$signed({2'b00, quo_dur}) : $signed({2'b00, quo_dur});
    ratio_sum  = ratio_amp + ratio_dur;
    ratio_half = (ratio_sum + $signed({{(SB-1){1'b0}}, ratio_sum[SB-1]})) >>> 1;
    tilt_value_nxt = last_flags.degen ? '0 : ratio_half[FRAC_BITS+1:0];
    out_valid_nxt  = advance ? stg_valid_r[QB-1] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      tilt_amp_r   <= stg_amp_r[QB-1];
      tilt_dur_r   <= stg_dur_r[QB-1];
      tilt_value_r <= tilt_value_nxt;
      degen_r      <= last_flags.degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tilt_amp   = tilt_amp_r;
  assign out_tilt_dur   = tilt_dur_r;
  assign out_tilt_value = tilt_value_r;
  assign out_degenerate = degen_r;

  // A degenerate event always reports a zero tilt.
  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && degen_r |-> tilt_value_r == '0)
    else $error("degenerate result with nonzero tilt");

  // Both quotients of a regular event stay within one in Q1.FRAC_BITS.
  a_quo_range : assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r[QB-1] && !last_flags.degen |->
      quo_amp <= QB'(1) << FRAC_BITS && quo_dur <= QB'(1) << FRAC_BITS)
    else $error("divider quotient out of range");

  // A stalled result register holds its beat into the next cycle.
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(tilt_value_r) && $stable(degen_r))
    else $error("result changed while stalled");

endmodule : rft_back

`default_nettype wire

// ----- sv/rise_fall_to_tilt_params.sv -----
// Top level of the rise/fall to tilt intonation parameter converter.
`default_nettype none

// Converts one intonation event (signed rise and fall amplitudes, rise and
// fall durations) into tilt form: total amplitude, total duration and a
// Q1.FRAC_BITS tilt that is the mean of the amplitude and duration tilts,
// each ratio truncated toward zero. A zero denominator forces tilt to 0 and
// raises out_degenerate. One event is accepted per clock cycle while the
// output is not stalled; a result passes through one front register, one
// queue slot, FRAC_BITS + 1 divider stages retiring one quotient bit each,
// and one result register. The divider depth sets the latency; the queue
// lets the front keep accepting while the back is stalled.
module rise_fall_to_tilt_params #(
  parameter int unsigned AMP_BITS  = rft_pkg::AMP_BITS_DEF,
  parameter int unsigned DUR_BITS  = rft_pkg::DUR_BITS_DEF,
  parameter int unsigned FRAC_BITS = rft_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [AMP_BITS-1:0]  in_rise_amp,
  input  wire logic signed [AMP_BITS-1:0]  in_fall_amp,
  input  wire logic        [DUR_BITS-1:0]  in_rise_dur,
  input  wire logic        [DUR_BITS-1:0]  in_fall_dur,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic             [AMP_BITS:0]    out_tilt_amp,
  output logic             [DUR_BITS:0]    out_tilt_dur,
  output logic signed      [FRAC_BITS+1:0] out_tilt_value,
  output logic                             out_degenerate
);

  localparam int unsigned Q_WIDTH = rft_pkg::FLAGS_BITS + 2 * AMP_BITS + 2 * DUR_BITS + 2;

  logic                f_valid, f_ready;
  rft_pkg::rft_flags_t f_flags;
  logic [AMP_BITS:0]   f_amp_sum;
  logic [AMP_BITS-1:0] f_amp_num;
  logic [DUR_BITS:0]   f_dur_sum;
  logic [DUR_BITS-1:0] f_dur_num;

  logic                q_valid, q_ready;
  logic [Q_WIDTH-1:0]  q_data;
  rft_pkg::rft_flags_t b_flags;
  logic [AMP_BITS:0]   b_amp_sum;
  logic [AMP_BITS-1:0] b_amp_num;
  logic [DUR_BITS:0]   b_dur_sum;
  logic [DUR_BITS-1:0] b_dur_num;

  rft_front #(.AMP_BITS(AMP_BITS), .DUR_BITS(DUR_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rise_amp (in_rise_amp),
    .in_fall_amp (in_fall_amp),
    .in_rise_dur (in_rise_dur),
    .in_fall_dur (in_fall_dur),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_flags   (f_flags),
    .out_amp_sum (f_amp_sum),
    .out_amp_num (f_amp_num),
    .out_dur_sum (f_dur_sum),
    .out_dur_num (f_dur_num)
  );

  rft_queue #(.WIDTH(Q_WIDTH), .DEPTH(rft_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_flags, f_amp_sum, f_amp_num, f_dur_sum, f_dur_num}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Unpack the queued beat.
  assign {b_flags, b_amp_sum, b_amp_num, b_dur_sum, b_dur_num} = q_data;

  rft_back #(.AMP_BITS(AMP_BITS), .DUR_BITS(DUR_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (q_valid),
    .in_ready       (q_ready),
    .in_flags       (b_flags),
    .in_amp_sum     (b_amp_sum),
    .in_amp_num     (b_amp_num),
    .in_dur_sum     (b_dur_sum),
    .in_dur_num     (b_dur_num),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tilt_amp   (out_tilt_amp),
    .out_tilt_dur   (out_tilt_dur),
    .out_tilt_value (out_tilt_value),
    .out_degenerate (out_degenerate)
  );

endmodule : rise_fall_to_tilt_params

`default_nettype wire

// ----- bench/rise_fall_to_tilt_params_tb.sv -----
// Self-checking testbench for the rise/fall to tilt intonation parameter converter.
`default_nettype none

module rise_fall_to_tilt_params_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AMP_W  = rft_pkg::AMP_BITS_DEF;
  localparam int unsigned DUR_W  = rft_pkg::DUR_BITS_DEF;
  localparam int unsigned FRAC_W = rft_pkg::FRAC_BITS_DEF;

  // The drain wait is longer than the unstalled latency, which leaves some margin.
  localparam int unsigned DRAIN_CYCLES = FRAC_W + 12;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_BEATS = 1430;

  // One expected result beat.
  typedef struct {
    logic        [AMP_W:0]    amp_total;
    logic        [DUR_W:0]    dur_total;
    logic signed [FRAC_W+1:0] tilt;
    logic                     degen;
  } tilt_result_t;

  // Predicts tilt parameters for each accepted event and checks result beats in order.
  class tilt_checker;
    tilt_result_t pending_tilts[$];
    int unsigned  mismatches;
    int unsigned  events_seen;
    int unsigned  results_seen;
    int unsigned  degenerate_seen;

    function new();
      mismatches      = 0;
      events_seen     = 0;
      results_seen    = 0;
      degenerate_seen = 0;
    endfunction

    // Fixed-point tilt computation; SystemVerilog signed division truncates toward zero.
    function tilt_result_t calc_tilt_params(logic signed [AMP_W-1:0] ra,
                                            logic signed [AMP_W-1:0] fa,
                                            logic [DUR_W-1:0] rd, logic [DUR_W-1:0] fd);
      longint       mag_r, mag_f, amp_sum, dur_sum, a_tilt, d_tilt, mean_tilt;
      tilt_result_t r;
      mag_r   = (ra < 0) ? -longint'(ra) : longint'(ra);
      mag_f   = (fa < 0) ? -longint'(fa) : longint'(fa);
      amp_sum = mag_r + mag_f;
      dur_sum = longint'(rd) + longint'(fd);
      mean_tilt = 0;
      r.degen = (amp_sum == 0) || (dur_sum == 0);
      if (!r.degen) begin
        a_tilt    = ((mag_r - mag_f) * (longint'(1) << FRAC_W)) / amp_sum;
        d_tilt    = ((longint'(rd) - longint'(fd)) * (longint'(1) << FRAC_W)) / dur_sum;
        mean_tilt = (a_tilt + d_tilt) / 2;
      end
      r.amp_total = amp_sum[AMP_W:0];
      r.dur_total = dur_sum[DUR_W:0];
      r.tilt      = mean_tilt[FRAC_W+1:0];
      return r;
    endfunction

    function void note_event(logic signed [AMP_W-1:0] ra, logic signed [AMP_W-1:0] fa,
                             logic [DUR_W-1:0] rd, logic [DUR_W-1:0] fd);
      pending_tilts.push_back(calc_tilt_params(ra, fa, rd, fd));
      events_seen++;
    endfunction

    function void check_result(logic [AMP_W:0] amp, logic [DUR_W:0] dur,
                               logic signed [FRAC_W+1:0] tilt, logic degen);
      tilt_result_t want;
      results_seen++;
      if (degen) degenerate_seen++;
      if (pending_tilts.size() == 0) begin
        $error("result beat with no event pending: tilt_amp=%0d tilt_dur=%0d", amp, dur);
        mismatches++;
        return;
      end
      want = pending_tilts.pop_front();
      if (amp !== want.amp_total) begin
        $error("tilt_amp: expected %0d, got %0d", want.amp_total, amp);
        mismatches++;
      end
      if (dur !== want.dur_total) begin
        $error("tilt_dur: expected %0d, got %0d", want.dur_total, dur);
        mismatches++;
      end
      if (tilt !== want.tilt) begin
        $error("tilt_value: expected %0d, got %0d", want.tilt, tilt);
        mismatches++;
      end
      if (degen !== want.degen) begin
        $error("degenerate: expected %0d, got %0d", want.degen, degen);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return pending_tilts.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [AMP_W-1:0]  in_rise_amp;
  logic signed [AMP_W-1:0]  in_fall_amp;
  logic        [DUR_W-1:0]  in_rise_dur;
  logic        [DUR_W-1:0]  in_fall_dur;
  logic                     out_valid;
  logic                     out_ready;
  logic        [AMP_W:0]    out_tilt_amp;
  logic        [DUR_W:0]    out_tilt_dur;
  logic signed [FRAC_W+1:0] out_tilt_value;
  logic                     out_degenerate;

  // Shared between the sender and the receiver processes.
  bit steady;
  bit hold_off_go;

  tilt_checker checker_h = new();

  rise_fall_to_tilt_params dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rise_amp    (in_rise_amp),
    .in_fall_amp    (in_fall_amp),
    .in_rise_dur    (in_rise_dur),
    .in_fall_dur    (in_fall_dur),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tilt_amp   (out_tilt_amp),
    .out_tilt_dur   (out_tilt_dur),
    .out_tilt_value (out_tilt_value),
    .out_degenerate (out_degenerate)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both handshakes are sampled at the edge, before any update made at that edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        checker_h.note_event(in_rise_amp, in_fall_amp, in_rise_dur, in_fall_dur);
      if (out_valid && out_ready)
        checker_h.check_result(out_tilt_amp, out_tilt_dur, out_tilt_value, out_degenerate);
    end
  end

  // Receiver: random backpressure, a quiet stretch, and one long hold-off.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Offers one event, with occasional idle cycles before it, and waits until it is taken.
  task automatic send_event(input logic signed [AMP_W-1:0] ra, input logic signed [AMP_W-1:0] fa,
                            input logic [DUR_W-1:0] rd, input logic [DUR_W-1:0] fd);
    while (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_rise_amp <= ra;
    in_fall_amp <= fa;
    in_rise_dur <= rd;
    in_fall_dur <= fd;
    do @(posedge clk); while (!in_ready);
  endtask

  // Amplitude mix: mostly full range, with small, extreme and zero values.
  function automatic logic [AMP_W-1:0] pick_amp();
    case ($urandom_range(9))
      6: return AMP_W'($urandom_range(128)) - AMP_W'(64);
      7: begin
        case ($urandom_range(3))
          0: return {1'b1, {(AMP_W-1){1'b0}}};
          1: return {1'b0, {(AMP_W-1){1'b1}}};
          2: return {AMP_W{1'b1}};
          default: return AMP_W'(1);
        endcase
      end
      8: return '0;
      default: return AMP_W'($urandom());
    endcase
  endfunction

  // Duration mix: mostly full range, with short, extreme and zero values.
  function automatic logic [DUR_W-1:0] pick_dur();
    case ($urandom_range(9))
      6, 9: return DUR_W'($urandom_range(20));
      7: return $urandom_range(1) ? {DUR_W{1'b1}} : '0;
      8: return '0;
      default: return DUR_W'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    localparam logic signed [AMP_W-1:0] AMP_MIN = {1'b1, {(AMP_W-1){1'b0}}};
    localparam logic signed [AMP_W-1:0] AMP_MAX = {1'b0, {(AMP_W-1){1'b1}}};
    localparam logic        [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};
    logic signed [AMP_W-1:0] ra, fa;
    logic        [DUR_W-1:0] rd, fd;
    steady      = 1'b0;
    hold_off_go = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_rise_amp <= '0;
    in_fall_amp <= '0;
    in_rise_dur <= '0;
    in_fall_dur <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: both denominators zero, then each one zero alone.
    send_event('0, '0, '0, '0);
    send_event('0, '0, 16'd40, 16'd60);
    send_event(16'sd800, -16'sd400, '0, '0);
    // Amplitude extremes, including the most negative value on both sides.
    send_event(AMP_MIN, AMP_MIN, 16'd100, 16'd100);
    send_event(AMP_MIN, AMP_MAX, 16'd1, 16'd2);
    send_event(AMP_MAX, AMP_MAX, DUR_MAX, DUR_MAX);
    send_event(AMP_MAX, AMP_MIN, DUR_MAX, '0);
    send_event(-16'sd1, 16'sd1, '0, DUR_MAX);
    // Pure rise and pure fall give tilt of plus and minus one.
    send_event(16'sd1600, '0, 16'd500, '0);
    send_event('0, -16'sd1600, '0, 16'd500);
    send_event(AMP_MIN, '0, DUR_MAX, '0);
    // Negative and inexact ratios, where truncation toward zero matters.
    send_event(16'sd1, -16'sd2, 16'd1, 16'd2);
    send_event(16'sd2, 16'sd3, 16'd2, 16'd3);
    send_event(-16'sd7, 16'sd3, 16'd3, 16'd7);
    send_event(16'sd3, -16'sd3, 16'd9, 16'd9);
    send_event(AMP_W'(16'h5555), AMP_W'(16'hAAAA), 16'h5555, 16'hAAAA);
    send_event(AMP_W'(16'h2AAA), AMP_W'(16'hD555), 16'hAAAA, 16'h5555);
    send_event(16'sd1, 16'sd0, 16'd0, 16'd1);

    // Random events; one long hold-off early and a stretch with no idling later.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 100) hold_off_go = 1'b1;
      steady = (i >= 500) && (i < 800);
      ra = pick_amp();
      fa = pick_amp();
      rd = pick_dur();
      fd = pick_dur();
      send_event(ra, fa, rd, fd);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Wait for every expected result, then drain a while longer for strays.
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d events and %0d result beats, %0d of them degenerate,",
             checker_h.events_seen, checker_h.results_seen, checker_h.degenerate_seen);
    $display("under random idling on both sides and a %0d-cycle receiver hold-off.",
             HOLD_CYCLES);
    if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
